// ===== rtl/scan_polar_to_cartesian_assert.svh =====
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCAN_POLAR_TO_CARTESIAN_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SPC_ASSERT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("spc: implication check failed");
// next-cycle implication
`define SPC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("spc: next-cycle check failed");
`else
`define SPC_ASSERT(name, clk, rstn, ante, cons)
`define SPC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the scan polar to Cartesian converter.
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam int RANGE_W   = 20;
	localparam int ANGLE_W   = 32;
	localparam int COORD_W   = 21;
	localparam int BEAM_W    = 12;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	localparam int FRAC_BITS = 16;
	localparam int XY_W      = 40;
	localparam int Z_W       = 33;
	localparam int Q_W       = XY_W - FRAC_BITS + 1;
	localparam int ATAN_W    = 30;
	localparam int TBL_IDX_W = 5;

	localparam logic [31:0] GAIN_INV_Q32 = 32'd2608131496;
	localparam int COORD_MAX = 1048575;
	localparam int COORD_MIN = -1048576;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 8'd3;

	localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 20'd0;
	localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 20'd1048575;

	// atan(2^-i) in binary-angle units, rounded
	localparam logic [ATAN_W-1:0] ATAN_TABLE [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_DONE
	} spc_state_t;

	typedef struct packed {
		logic                 prep;
		logic                 step;
		logic [TBL_IDX_W-1:0] iter;
	} cordic_ctl_t;

endpackage

// ===== rtl/spc_if.sv =====
// ----------------------------------------------------------------------------
// spc_if
// Valid/ready channel interfaces: samples in, points out, register writes.
// ----------------------------------------------------------------------------
interface spc_sample_if
	import spc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [RANGE_W-1:0] range_sample;
	logic               last_in_scan;

	modport source (output valid, range_sample, last_in_scan, input ready);
	modport sink   (input valid, range_sample, last_in_scan, output ready);
endinterface

interface spc_point_if
	import spc_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic                      point_valid;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [BEAM_W-1:0]         beam_index;
	logic                      scan_end;

	modport source (output valid, point_valid, point_x, point_y, beam_index, scan_end,
		input ready);
	modport sink   (input valid, point_valid, point_x, point_y, beam_index, scan_end,
		output ready);
endinterface

interface spc_cfg_if
	import spc_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/spc_cordic.sv =====
// ----------------------------------------------------------------------------
// spc_cordic
// Rotation-mode CORDIC datapath, one micro-rotation per step command,
// followed by quadrant fix-up and rounding to saturated coordinates.
// ----------------------------------------------------------------------------
module spc_cordic
	import spc_pkg::*;
(
	input  logic                      clk,
	input  cordic_ctl_t               ctl,
	input  logic [RANGE_W-1:0]        range_sample,
	input  logic [ANGLE_W-1:0]        angle,
	output logic signed [COORD_W-1:0] coord_x,
	output logic signed [COORD_W-1:0] coord_y
);

	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(COORD_MAX);
	localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(COORD_MIN);
	localparam logic signed [XY_W:0]  HALF  = (XY_W+1)'(1 << (FRAC_BITS - 1));

	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [1:0]             quad_q;

	logic [RANGE_W+31:0]    gain_prod;
	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic [Z_W-1:0]         atan_ext;
	logic signed [XY_W-1:0] rot_x;
	logic signed [XY_W-1:0] rot_y;

	function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
		logic signed [XY_W:0]  s;
		logic signed [Q_W-1:0] q;
		s = (XY_W+1)'(v) + HALF;
		q = s[XY_W:FRAC_BITS];
		if (q > Q_MAX)
			return COORD_W'(Q_MAX);
		else if (q < Q_MIN)
			return COORD_W'(Q_MIN);
		else
			return COORD_W'(q);
	endfunction

	assign gain_prod = (RANGE_W+32)'(range_sample) * (RANGE_W+32)'(GAIN_INV_Q32);
	assign dx        = y_q >>> ctl.iter;
	assign dy        = x_q >>> ctl.iter;
	assign atan_ext  = {{(Z_W-ATAN_W){1'b0}}, ATAN_TABLE[ctl.iter]};

	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			x_q    <= XY_W'(gain_prod[RANGE_W+31:FRAC_BITS]);
			y_q    <= '0;
			z_q    <= Z_W'(angle[ANGLE_W-3:0]);
			quad_q <= angle[ANGLE_W-1:ANGLE_W-2];
		end else if (ctl.step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_ext;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_ext;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd1: begin
				rot_x = -y_q;
				rot_y = x_q;
			end
			2'd2: begin
				rot_x = -x_q;
				rot_y = -y_q;
			end
			2'd3: begin
				rot_x = y_q;
				rot_y = -x_q;
			end
			default: begin
				rot_x = x_q;
				rot_y = y_q;
			end
		endcase
	end

	assign coord_x = round_sat(rot_x);
	assign coord_y = round_sat(rot_y);

endmodule

// ===== rtl/scan_polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian
// Lidar range samples to Cartesian points through a shared CORDIC unit.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one range sample per transfer, with the end-of-sweep mark.
//   points  : one point per sample: validity, x, y, beam index, sweep end.
//   cfg     : register writes, always ready; index 0 min_range, 1 max_range,
//             2 start_angle, 3 angle_step; other indexes are dropped.
//             Write only while no sample is in flight.
//   After a sample transfer the unit steps through PREP, ITER and DONE;
//   DONE loads the output register. samples.ready is high only while the
//   unit is idle, so a new sample waits until the last one leaves DONE;
//   the single micro-rotation stage is iterated once per cycle in ITER.
//   A finished point sits in the output register; the next sample is
//   taken while it waits. If points stalls, the following sample holds
//   in the last state until the output register frees up.
//   Reset clears the beam counter, the output valid and the registers
//   to min_range 0, max_range 1048575, start_angle 0, angle_step 0.
// ----------------------------------------------------------------------------
`include "scan_polar_to_cartesian_assert.svh"

module scan_polar_to_cartesian
	import spc_pkg::*;
#(
	parameter int MAX_SCAN_POINTS = 4096,
	parameter int CORDIC_STEPS    = 20
) (
	input logic         clk,
	input logic         arst_n,
	spc_sample_if.sink  samples,
	spc_point_if.source points,
	spc_cfg_if.sink     cfg
);

	localparam int CNT_W  = $clog2(MAX_SCAN_POINTS);
	localparam int ITER_W = $clog2(CORDIC_STEPS);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_SCAN_POINTS - 1);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

	spc_state_t state_q;
	spc_state_t state_nxt;

	logic [RANGE_W-1:0]   min_range_q;
	logic [RANGE_W-1:0]   max_range_q;
	logic [ANGLE_W-1:0]   start_angle_q;
	logic [ANGLE_W-1:0]   angle_step_q;

	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [RANGE_W-1:0]   range_q;
	logic                 last_q;
	logic                 in_win_q;
	logic [ITER_W-1:0]    iter_q;

	logic                      o_valid_q;
	logic                      o_pv_q;
	logic signed [COORD_W-1:0] o_x_q;
	logic signed [COORD_W-1:0] o_y_q;
	logic [BEAM_W-1:0]         o_beam_q;
	logic                      o_end_q;

	logic                      in_xfer;
	logic                      out_xfer;
	logic                      out_free;
	logic                      out_load;
	logic                      cfg_xfer;
	cordic_ctl_t               ctl;
	logic [ANGLE_W-1:0]        angle;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_xfer       = samples.valid && samples.ready;
	assign out_xfer      = points.valid && points.ready;
	assign out_free      = !o_valid_q || points.ready;
	assign cfg_xfer      = cfg.valid && cfg.ready;
	assign angle         = start_angle_q + ANGLE_W'(ANGLE_W'(idx_q) * angle_step_q);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q   <= MIN_RANGE_RST;
			max_range_q   <= MAX_RANGE_RST;
			start_angle_q <= '0;
			angle_step_q  <= '0;
		end else if (cfg_xfer) begin
			unique case (cfg.index)
				CFG_MIN_RANGE:   min_range_q   <= cfg.data[RANGE_W-1:0];
				CFG_MAX_RANGE:   max_range_q   <= cfg.data[RANGE_W-1:0];
				CFG_START_ANGLE: start_angle_q <= cfg.data[ANGLE_W-1:0];
				CFG_ANGLE_STEP:  angle_step_q  <= cfg.data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_xfer) begin
				if (samples.last_in_scan)
					cnt_q <= '0;
				else if (cnt_q < CNT_LAST)
					cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.prep)
				iter_q <= '0;
			else if (ctl.step)
				iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			range_q  <= samples.range_sample;
			last_q   <= samples.last_in_scan;
			idx_q    <= cnt_q;
			in_win_q <= (samples.range_sample >= min_range_q) &&
				(samples.range_sample <= max_range_q);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer)
					state_nxt = ST_PREP;
			end
			ST_PREP: state_nxt = ST_ITER;
			ST_ITER: begin
				if (iter_q == ITER_LAST)
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_PREP: ctl.prep = 1'b1;
			ST_ITER: begin
				ctl.step = 1'b1;
				ctl.iter = TBL_IDX_W'(iter_q);
			end
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	spc_cordic u_cordic (
		.clk          (clk),
		.ctl          (ctl),
		.range_sample (range_q),
		.angle        (angle),
		.coord_x      (coord_x),
		.coord_y      (coord_y)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid_q <= 1'b0;
		else if (out_load)
			o_valid_q <= 1'b1;
		else if (out_xfer)
			o_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_pv_q   <= in_win_q;
			o_x_q    <= in_win_q ? coord_x : '0;
			o_y_q    <= in_win_q ? coord_y : '0;
			o_beam_q <= BEAM_W'(idx_q);
			o_end_q  <= last_q;
		end
	end

	assign points.valid       = o_valid_q;
	assign points.point_valid = o_pv_q;
	assign points.point_x     = o_x_q;
	assign points.point_y     = o_y_q;
	assign points.beam_index  = o_beam_q;
	assign points.scan_end    = o_end_q;

	`SPC_ASSERT_NEXT(a_iter_ends, clk, arst_n, (state_q == ST_ITER) && (iter_q == ITER_LAST), state_q == ST_DONE)
	`SPC_ASSERT(a_load_from_done, clk, arst_n, $rose(o_valid_q), $past(state_q == ST_DONE))
	`SPC_ASSERT(a_invalid_zero, clk, arst_n, o_valid_q && !o_pv_q, (o_x_q == '0) && (o_y_q == '0))
	`SPC_ASSERT(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_LAST)

endmodule
